/* sv/dtyp_pkg.sv */
// Shared types, constants and the arctangent table for the direction-to-yaw/pitch pipeline.
package dtyp_pkg;

  // CORDIC datapath width: a coordinate difference is pre-scaled so that it always
  // occupies 59 bits, plus headroom for the CORDIC gain and the diagonal length.
  localparam int CORDIC_W = 62;
  // Angle accumulators hold degrees with TAB_FRAC fraction bits.
  localparam int TAB_FRAC = 24;
  localparam int ANG_W    = 35;
  localparam int ATAN_W   = 30;

  // Inverse CORDIC gain, 1/K truncated to 30 fraction bits.
  localparam int GAIN_SHIFT = 30;
  localparam logic [ATAN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

  // Plus ninety degrees in accumulator format.
  localparam logic signed [ANG_W-1:0] Z_90 = 35'sd1509949440;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANG_W-1:0]    z;
    logic                       zero;
  } vec_t;

  // round(atan(2^-i) * 180/pi * 2^24)
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 30'd754974720;
      5'd1:    val = 30'd445687602;
      5'd2:    val = 30'd235489088;
      5'd3:    val = 30'd119537938;
      5'd4:    val = 30'd60000934;
      5'd5:    val = 30'd30029717;
      5'd6:    val = 30'd15018523;
      5'd7:    val = 30'd7509720;
      5'd8:    val = 30'd3754917;
      5'd9:    val = 30'd1877466;
      5'd10:   val = 30'd938734;
      5'd11:   val = 30'd469367;
      5'd12:   val = 30'd234684;
      5'd13:   val = 30'd117342;
      5'd14:   val = 30'd58671;
      5'd15:   val = 30'd29335;
      5'd16:   val = 30'd14668;
      5'd17:   val = 30'd7334;
      5'd18:   val = 30'd3667;
      5'd19:   val = 30'd1833;
      5'd20:   val = 30'd917;
      5'd21:   val = 30'd458;
      5'd22:   val = 30'd229;
      5'd23:   val = 30'd115;
      5'd24:   val = 30'd57;
      5'd25:   val = 30'd29;
      5'd26:   val = 30'd14;
      5'd27:   val = 30'd7;
      5'd28:   val = 30'd4;
      5'd29:   val = 30'd2;
      5'd30:   val = 30'd1;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage

/* sv/dtyp_prep.sv */
// Input stages: coordinate differences, pre-scaling and the quadrant pre-rotation for yaw.
module dtyp_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [COORD_WIDTH-1:0]         from_x_i,
  input  logic signed [COORD_WIDTH-1:0]         from_y_i,
  input  logic signed [COORD_WIDTH-1:0]         from_z_i,
  input  logic signed [COORD_WIDTH-1:0]         to_x_i,
  input  logic signed [COORD_WIDTH-1:0]         to_y_i,
  input  logic signed [COORD_WIDTH-1:0]         to_z_i,
  output logic                                  valid_o,
  output dtyp_pkg::vec_t                        vec_o,
  output logic signed [dtyp_pkg::CORDIC_W-1:0]  dy_o
);
  import dtyp_pkg::*;

  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int PRESCALE = 58 - COORD_WIDTH;

  logic                     diff_valid_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dz_d;

  logic                       rot_valid_q;
  vec_t                       vec_q, vec_d;
  logic signed [CORDIC_W-1:0] dy_s_q, dy_s_d;
  logic signed [CORDIC_W-1:0] sx, sz;

  always_comb begin
    dx_d = DIFF_W'(to_x_i) - DIFF_W'(from_x_i);
    dy_d = DIFF_W'(to_y_i) - DIFF_W'(from_y_i);
    dz_d = DIFF_W'(to_z_i) - DIFF_W'(from_z_i);
  end

  // A vector in the left half plane is turned by a quarter turn first, so the
  // iterations only see x >= 0.
  always_comb begin
    sx     = CORDIC_W'(dx_q) <<< PRESCALE;
    sz     = CORDIC_W'(dz_q) <<< PRESCALE;
    dy_s_d = CORDIC_W'(dy_q) <<< PRESCALE;
    vec_d.zero = (sx == '0) && (sz == '0);
    if (sx < 0) begin
      if (sz >= 0) begin
        vec_d.x = sz;
        vec_d.y = -sx;
        vec_d.z = Z_90;
      end else begin
        vec_d.x = -sz;
        vec_d.y = sx;
        vec_d.z = -Z_90;
      end
    end else begin
      vec_d.x = sx;
      vec_d.y = sz;
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_valid_q <= 1'b0;
      rot_valid_q  <= 1'b0;
    end else begin
      diff_valid_q <= valid_i;
      rot_valid_q  <= diff_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dz_q   <= dz_d;
    vec_q  <= vec_d;
    dy_s_q <= dy_s_d;
  end

  assign valid_o = rot_valid_q;
  assign vec_o   = vec_q;
  assign dy_o    = dy_s_q;

endmodule

/* sv/dtyp_cordic.sv */
// Pipelined CORDIC vectoring unit: one micro-rotation per register stage, payload alongside.
module dtyp_cordic #(
  parameter int STAGES = 24,
  parameter int PAY_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dtyp_pkg::vec_t   vec_i,
  input  logic [PAY_W-1:0] pay_i,
  output logic             valid_o,
  output dtyp_pkg::vec_t   vec_o,
  output logic [PAY_W-1:0] pay_o
);
  import dtyp_pkg::*;

  logic             valid_q [STAGES];
  vec_t             vec_q   [STAGES];
  logic [PAY_W-1:0] pay_q   [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN_C = ANG_W'(atan_deg(5'(i)));

    logic                       v_in;
    vec_t                       cur, nxt;
    logic [PAY_W-1:0]           p_in;
    logic signed [CORDIC_W-1:0] x_c, y_c, xs, ys;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign cur  = vec_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign v_in = valid_q[i-1];
      assign cur  = vec_q[i-1];
      assign p_in = pay_q[i-1];
    end

    always_comb begin
      x_c      = cur.x;
      y_c      = cur.y;
      xs       = x_c >>> i;
      ys       = y_c >>> i;
      nxt.zero = cur.zero;
      if (y_c >= 0) begin
        nxt.x = x_c + ys;
        nxt.y = y_c - xs;
        nxt.z = cur.z + ATAN_C;
      end else begin
        nxt.x = x_c - ys;
        nxt.y = y_c + xs;
        nxt.z = cur.z - ATAN_C;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      vec_q[i] <= nxt;
      pay_q[i] <= p_in;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign vec_o   = vec_q[STAGES-1];
  assign pay_o   = pay_q[STAGES-1];

endmodule

/* sv/dtyp_gain.sv */
// Gain removal of the horizontal length and setup of the pitch CORDIC operands.
module dtyp_gain (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  dtyp_pkg::vec_t                        vec_i,
  input  logic signed [dtyp_pkg::CORDIC_W-1:0]  dy_i,
  output logic                                  valid_o,
  output dtyp_pkg::vec_t                        vec_o,
  output logic signed [dtyp_pkg::ANG_W-1:0]     yaw_z_o
);
  import dtyp_pkg::*;

  localparam int U_W  = CORDIC_W - 1;
  localparam int HI_W = U_W - GAIN_SHIFT;
  localparam int PH_W = HI_W + ATAN_W;
  localparam int PL_W = GAIN_SHIFT + ATAN_W;

  logic [U_W-1:0]  mag_u;
  logic [PH_W-1:0] prod_hi_d, prod_hi_q;
  logic [PL_W-1:0] prod_lo_d, prod_lo_q;
  logic signed [ANG_W-1:0]    yaw_z_d, yaw_z_q, yaw_z2_q;
  logic signed [CORDIC_W-1:0] dy_q;
  logic                       mul_valid_q, out_valid_q;
  vec_t                       vec_d, vec_q;
  logic signed [CORDIC_W-1:0] hlen;

  // The length is split at bit 30 so each product stays within 31 x 30 bits.
  always_comb begin
    mag_u     = vec_i.x[CORDIC_W-1] ? '0 : vec_i.x[U_W-1:0];
    prod_hi_d = PH_W'(mag_u[U_W-1:GAIN_SHIFT]) * PH_W'(INV_GAIN_Q30);
    prod_lo_d = PL_W'(mag_u[GAIN_SHIFT-1:0]) * PL_W'(INV_GAIN_Q30);
    yaw_z_d   = vec_i.zero ? '0 : vec_i.z;
  end

  always_comb begin
    hlen       = CORDIC_W'(prod_hi_q) + CORDIC_W'(prod_lo_q >> GAIN_SHIFT);
    vec_d.x    = hlen;
    vec_d.y    = dy_q;
    vec_d.z    = '0;
    vec_d.zero = (hlen == '0) && (dy_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= valid_i;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_hi_q <= prod_hi_d;
    prod_lo_q <= prod_lo_d;
    yaw_z_q   <= yaw_z_d;
    dy_q      <= dy_i;
    vec_q     <= vec_d;
    yaw_z2_q  <= yaw_z_q;
  end

  assign valid_o = out_valid_q;
  assign vec_o   = vec_q;
  assign yaw_z_o = yaw_z2_q;

endmodule

/* sv/dtyp_finish.sv */
// Output stages: rounding to the output format, yaw offset and range clamps.
module dtyp_finish #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  dtyp_pkg::vec_t                      vec_i,
  input  logic signed [dtyp_pkg::ANG_W-1:0]   yaw_z_i,
  output logic                                valid_o,
  output logic signed [ANGLE_FRAC_BITS+9:0]   yaw_deg_o,
  output logic signed [ANGLE_FRAC_BITS+7:0]   pitch_deg_o
);
  import dtyp_pkg::*;

  localparam int YAW_W   = ANGLE_FRAC_BITS + 10;
  localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
  localparam int SHIFT   = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] HALF    = ANG_W'((1 << SHIFT) >> 1);
  localparam logic signed [ANG_W-1:0] DEG_90  = ANG_W'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] DEG_270 = ANG_W'(270) <<< ANGLE_FRAC_BITS;

  logic                    rnd_valid_q, out_valid_q;
  logic signed [ANG_W-1:0] pitch_z;
  logic signed [ANG_W-1:0] yaw_r_d, yaw_r_q, pitch_r_d, pitch_r_q;
  logic signed [ANG_W-1:0] yaw_c, pitch_c;
  logic signed [YAW_W-1:0]   yaw_deg_q;
  logic signed [PITCH_W-1:0] pitch_deg_q;

  // Rounding is half up; pitch is negated before it is rounded.
  always_comb begin
    pitch_z   = vec_i.zero ? '0 : -vec_i.z;
    yaw_r_d   = ((yaw_z_i + HALF) >>> SHIFT) - DEG_90;
    pitch_r_d = (pitch_z + HALF) >>> SHIFT;
  end

  always_comb begin
    if (yaw_r_q < -DEG_270) begin
      yaw_c = -DEG_270;
    end else if (yaw_r_q > DEG_90) begin
      yaw_c = DEG_90;
    end else begin
      yaw_c = yaw_r_q;
    end
    if (pitch_r_q < -DEG_90) begin
      pitch_c = -DEG_90;
    end else if (pitch_r_q > DEG_90) begin
      pitch_c = DEG_90;
    end else begin
      pitch_c = pitch_r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rnd_valid_q <= valid_i;
      out_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_r_q     <= yaw_r_d;
    pitch_r_q   <= pitch_r_d;
    yaw_deg_q   <= yaw_c[YAW_W-1:0];
    pitch_deg_q <= pitch_c[PITCH_W-1:0];
  end

  assign valid_o     = out_valid_q;
  assign yaw_deg_o   = yaw_deg_q;
  assign pitch_deg_o = pitch_deg_q;

endmodule

/* sv/direction_to_yaw_pitch.sv */
// Top level: yaw and pitch angles of the vector between two points, fully pipelined.
//
//   channel   ports                               handshake
//   --------  ----------------------------------  ---------------------------------
//   command   from_{x,y,z}_i, to_{x,y,z}_i        beat when start_i && !busy_o
//   result    yaw_deg_o, pitch_deg_o              beat in each cycle with done_o
//
// One beat enters per clock; busy_o stays low. Each command passes through two
// input stages, the yaw CORDIC, two gain stages, the pitch CORDIC and two output
// stages before its result comes out.
// Reset clears only the valid bits of the pipeline. The receiver cannot stall, so
// every stage advances in every cycle.
module direction_to_yaw_pitch #(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [COORD_WIDTH-1:0]      from_x_i,
  input  logic signed [COORD_WIDTH-1:0]      from_y_i,
  input  logic signed [COORD_WIDTH-1:0]      from_z_i,
  input  logic signed [COORD_WIDTH-1:0]      to_x_i,
  input  logic signed [COORD_WIDTH-1:0]      to_y_i,
  input  logic signed [COORD_WIDTH-1:0]      to_z_i,
  output logic                               done_o,
  output logic signed [ANGLE_FRAC_BITS+9:0]  yaw_deg_o,
  output logic signed [ANGLE_FRAC_BITS+7:0]  pitch_deg_o
);
  import dtyp_pkg::*;

  logic                       prep_valid, yaw_valid, gain_valid, pitch_valid;
  vec_t                       prep_vec, yaw_vec, gain_vec, pitch_vec;
  logic signed [CORDIC_W-1:0] prep_dy;
  logic [CORDIC_W-1:0]        yaw_pay;
  logic signed [ANG_W-1:0]    gain_yaw_z;
  logic [ANG_W-1:0]           pitch_pay;

  assign busy_o = 1'b0;

  dtyp_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .from_x_i (from_x_i),
    .from_y_i (from_y_i),
    .from_z_i (from_z_i),
    .to_x_i   (to_x_i),
    .to_y_i   (to_y_i),
    .to_z_i   (to_z_i),
    .valid_o  (prep_valid),
    .vec_o    (prep_vec),
    .dy_o     (prep_dy)
  );

  dtyp_cordic #(
    .STAGES(CORDIC_STAGES),
    .PAY_W (CORDIC_W)
  ) u_yaw_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .vec_i   (prep_vec),
    .pay_i   (prep_dy),
    .valid_o (yaw_valid),
    .vec_o   (yaw_vec),
    .pay_o   (yaw_pay)
  );

  dtyp_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (yaw_valid),
    .vec_i   (yaw_vec),
    .dy_i    (signed'(yaw_pay)),
    .valid_o (gain_valid),
    .vec_o   (gain_vec),
    .yaw_z_o (gain_yaw_z)
  );

  dtyp_cordic #(
    .STAGES(CORDIC_STAGES),
    .PAY_W (ANG_W)
  ) u_pitch_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gain_valid),
    .vec_i   (gain_vec),
    .pay_i   (gain_yaw_z),
    .valid_o (pitch_valid),
    .vec_o   (pitch_vec),
    .pay_o   (pitch_pay)
  );

  dtyp_finish #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pitch_valid),
    .vec_i       (pitch_vec),
    .yaw_z_i     (signed'(pitch_pay)),
    .valid_o     (done_o),
    .yaw_deg_o   (yaw_deg_o),
    .pitch_deg_o (pitch_deg_o)
  );

endmodule
